// ----- hdl/qoj_pkg.sv -----
// shared types, constants and microcode for the quaternion orientation jog block
package qoj_pkg;

	// cordic iteration count, limited by the arctangent table
	localparam int CORDIC_STEPS = 16;
	localparam int AtanEntries = 24;
	localparam int CordicIters = (CORDIC_STEPS > AtanEntries) ? AtanEntries : CORDIC_STEPS;

	// angle constants in Q30 radians, and unity in Q14
	localparam logic signed [34:0] PiQ30 = 35'sd3373259426;
	localparam logic signed [34:0] HalfPiQ30 = 35'sd1686629713;
	localparam logic signed [15:0] OneQ14 = 16'sd16384;

	// item kinds
	localparam logic [1:0] KIND_ROTATE = 2'd0;
	localparam logic [1:0] KIND_LOAD = 2'd1;
	localparam logic [1:0] KIND_ACCEPT = 2'd2;
	localparam logic [1:0] KIND_REJECT = 2'd3;

	// body axis codes
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;
	localparam logic [1:0] AXIS_NONE = 2'd3;

	// microcode program layout
	localparam int PcW = 7;
	localparam logic [PcW-1:0] PcAxisX = 7'd0;
	localparam logic [PcW-1:0] PcAxisY = 7'd14;
	localparam logic [PcW-1:0] PcAxisZ = 7'd28;
	localparam logic [PcW-1:0] PcRot = 7'd42;

	typedef enum logic [1:0] {UOP_NOP, UOP_MAC, UOP_STORE} uop_kind_t;
	typedef enum logic [3:0] {A_Q0, A_Q1, A_Q2, A_Q3, A_R0, A_R1, A_R2, A_R3, A_CY} asel_t;
	typedef enum logic [2:0] {B_Q0, B_Q1, B_Q2, B_Q3, B_U0, B_U1, B_U2} bsel_t;
	typedef enum logic [2:0] {D_V0, D_V1, D_V2, D_V3, D_R1, D_R2, D_R3} dsel_t;

	typedef struct packed {
		uop_kind_t op;
		asel_t a;
		bsel_t b;
		logic neg;
		logic dbl;
		logic clr;
		dsel_t dst;
		logic last;
	} uop_t;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic load_att;
		logic save;
		logic restore;
		logic show;
		logic start_norm;
		logic norm_four;
		logic start_cordic;
		logic take_u;
		logic take_att;
		uop_t uop;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic norm_busy;
		logic norm_ok;
		logic cordic_busy;
	} status_t;

	function automatic uop_t nop();
		uop_t u;
		u = '0;
		u.op = UOP_NOP;
		return u;
	endfunction

	function automatic uop_t mac(asel_t a, bsel_t b, logic neg, logic dbl, logic clr);
		uop_t u;
		u = '0;
		u.op = UOP_MAC;
		u.a = a;
		u.b = b;
		u.neg = neg;
		u.dbl = dbl;
		u.clr = clr;
		return u;
	endfunction

	function automatic uop_t st(dsel_t dst, logic last);
		uop_t u;
		u = '0;
		u.op = UOP_STORE;
		u.dst = dst;
		u.last = last;
		return u;
	endfunction

	// microcode: world axis per body axis, then rotation quaternion and product
	function automatic uop_t ucode(logic [PcW-1:0] pc);
		uop_t u;
		unique case (pc)
			// x axis: (w2+x2-y2-z2, 2(xy+wz), 2(xz-wy))
			7'd0: u = mac(A_Q0, B_Q0, 1'b0, 1'b0, 1'b1);
			7'd1: u = mac(A_Q1, B_Q1, 1'b0, 1'b0, 1'b0);
			7'd2: u = mac(A_Q2, B_Q2, 1'b1, 1'b0, 1'b0);
			7'd3: u = mac(A_Q3, B_Q3, 1'b1, 1'b0, 1'b0);
			7'd4: u = nop();
			7'd5: u = st(D_V0, 1'b0);
			7'd6: u = mac(A_Q1, B_Q2, 1'b0, 1'b1, 1'b1);
			7'd7: u = mac(A_Q0, B_Q3, 1'b0, 1'b1, 1'b0);
			7'd8: u = nop();
			7'd9: u = st(D_V1, 1'b0);
			7'd10: u = mac(A_Q1, B_Q3, 1'b0, 1'b1, 1'b1);
			7'd11: u = mac(A_Q0, B_Q2, 1'b1, 1'b1, 1'b0);
			7'd12: u = nop();
			7'd13: u = st(D_V2, 1'b1);
			// y axis: (2(xy-wz), w2-x2+y2-z2, 2(yz+wx))
			7'd14: u = mac(A_Q1, B_Q2, 1'b0, 1'b1, 1'b1);
			7'd15: u = mac(A_Q0, B_Q3, 1'b1, 1'b1, 1'b0);
			7'd16: u = nop();
			7'd17: u = st(D_V0, 1'b0);
			7'd18: u = mac(A_Q0, B_Q0, 1'b0, 1'b0, 1'b1);
			7'd19: u = mac(A_Q1, B_Q1, 1'b1, 1'b0, 1'b0);
			7'd20: u = mac(A_Q2, B_Q2, 1'b0, 1'b0, 1'b0);
			7'd21: u = mac(A_Q3, B_Q3, 1'b1, 1'b0, 1'b0);
			7'd22: u = nop();
			7'd23: u = st(D_V1, 1'b0);
			7'd24: u = mac(A_Q2, B_Q3, 1'b0, 1'b1, 1'b1);
			7'd25: u = mac(A_Q0, B_Q1, 1'b0, 1'b1, 1'b0);
			7'd26: u = nop();
			7'd27: u = st(D_V2, 1'b1);
			// z axis: (2(xz+wy), 2(yz-wx), w2-x2-y2+z2)
			7'd28: u = mac(A_Q1, B_Q3, 1'b0, 1'b1, 1'b1);
			7'd29: u = mac(A_Q0, B_Q2, 1'b0, 1'b1, 1'b0);
			7'd30: u = nop();
			7'd31: u = st(D_V0, 1'b0);
			7'd32: u = mac(A_Q2, B_Q3, 1'b0, 1'b1, 1'b1);
			7'd33: u = mac(A_Q0, B_Q1, 1'b1, 1'b1, 1'b0);
			7'd34: u = nop();
			7'd35: u = st(D_V1, 1'b0);
			7'd36: u = mac(A_Q0, B_Q0, 1'b0, 1'b0, 1'b1);
			7'd37: u = mac(A_Q1, B_Q1, 1'b1, 1'b0, 1'b0);
			7'd38: u = mac(A_Q2, B_Q2, 1'b1, 1'b0, 1'b0);
			7'd39: u = mac(A_Q3, B_Q3, 1'b0, 1'b0, 1'b0);
			7'd40: u = nop();
			7'd41: u = st(D_V2, 1'b1);
			// rotation vector part: sine times unit axis
			7'd42: u = mac(A_CY, B_U0, 1'b0, 1'b0, 1'b1);
			7'd43: u = nop();
			7'd44: u = st(D_R1, 1'b0);
			7'd45: u = mac(A_CY, B_U1, 1'b0, 1'b0, 1'b1);
			7'd46: u = nop();
			7'd47: u = st(D_R2, 1'b0);
			7'd48: u = mac(A_CY, B_U2, 1'b0, 1'b0, 1'b1);
			7'd49: u = nop();
			7'd50: u = st(D_R3, 1'b0);
			// left product r * q
			7'd51: u = mac(A_R0, B_Q0, 1'b0, 1'b0, 1'b1);
			7'd52: u = mac(A_R1, B_Q1, 1'b1, 1'b0, 1'b0);
			7'd53: u = mac(A_R2, B_Q2, 1'b1, 1'b0, 1'b0);
			7'd54: u = mac(A_R3, B_Q3, 1'b1, 1'b0, 1'b0);
			7'd55: u = nop();
			7'd56: u = st(D_V0, 1'b0);
			7'd57: u = mac(A_R0, B_Q1, 1'b0, 1'b0, 1'b1);
			7'd58: u = mac(A_R1, B_Q0, 1'b0, 1'b0, 1'b0);
			7'd59: u = mac(A_R2, B_Q3, 1'b0, 1'b0, 1'b0);
			7'd60: u = mac(A_R3, B_Q2, 1'b1, 1'b0, 1'b0);
			7'd61: u = nop();
			7'd62: u = st(D_V1, 1'b0);
			7'd63: u = mac(A_R0, B_Q2, 1'b0, 1'b0, 1'b1);
			7'd64: u = mac(A_R1, B_Q3, 1'b1, 1'b0, 1'b0);
			7'd65: u = mac(A_R2, B_Q0, 1'b0, 1'b0, 1'b0);
			7'd66: u = mac(A_R3, B_Q1, 1'b0, 1'b0, 1'b0);
			7'd67: u = nop();
			7'd68: u = st(D_V2, 1'b0);
			7'd69: u = mac(A_R0, B_Q3, 1'b0, 1'b0, 1'b1);
			7'd70: u = mac(A_R1, B_Q2, 1'b0, 1'b0, 1'b0);
			7'd71: u = mac(A_R2, B_Q1, 1'b1, 1'b0, 1'b0);
			7'd72: u = mac(A_R3, B_Q0, 1'b0, 1'b0, 1'b0);
			7'd73: u = nop();
			7'd74: u = st(D_V3, 1'b1);
			default: u = nop();
		endcase
		return u;
	endfunction

	// arctangent of 2^-i in Q30, truncated
	function automatic logic [31:0] atan_q30(logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0: r = 32'h3243F6A8;
			5'd1: r = 32'h1DAC6705;
			5'd2: r = 32'h0FADBAFC;
			5'd3: r = 32'h07F56EA6;
			5'd4: r = 32'h03FEAB76;
			5'd5: r = 32'h01FFD55B;
			5'd6: r = 32'h00FFFAAA;
			5'd7: r = 32'h007FFF55;
			5'd8: r = 32'h003FFFEA;
			5'd9: r = 32'h001FFFFD;
			5'd10: r = 32'h000FFFFF;
			5'd11: r = 32'h0007FFFF;
			5'd12: r = 32'h0003FFFF;
			5'd13: r = 32'h0001FFFF;
			5'd14: r = 32'h0000FFFF;
			5'd15: r = 32'h00007FFF;
			5'd16: r = 32'h00003FFF;
			5'd17: r = 32'h00001FFF;
			5'd18: r = 32'h00000FFF;
			5'd19: r = 32'h000007FF;
			5'd20: r = 32'h000003FF;
			5'd21: r = 32'h000001FF;
			5'd22: r = 32'h000000FF;
			5'd23: r = 32'h0000007F;
			default: r = 32'h00000000;
		endcase
		return r;
	endfunction

endpackage

// ----- hdl/qoj_norm.sv -----
// iterative normalizer: scale, sum of squares, integer square root, division
module qoj_norm (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic four,
	input logic signed [63:0] vec [4],
	output logic busy,
	output logic ok,
	output logic signed [15:0] res [4]
);
	import qoj_pkg::*;

	typedef enum logic [2:0] {N_IDLE, N_SHIFT, N_SQ, N_ROOT, N_DLOAD, N_DIV} nstate_t;

	nstate_t state_q;
	logic [63:0] m_q [4];
	logic neg_q [4];
	logic [4:0] cnt_q;
	logic [1:0] el_q;
	logic [47:0] sq_s1;
	logic sq_v_s1;
	logic [49:0] rn_q;
	logic [50:0] root_q;
	logic [15:0] div_lo_q;
	logic [26:0] rem_q;
	logic [15:0] quo_q;
	logic ok_q;
	logic signed [15:0] res_q [4];

	logic [63:0] top, top01, top23;
	logic [50:0] rbit, rsum;
	logic [38:0] num;
	logic [26:0] rem_t, dvs;
	logic qbit;
	logic [15:0] qf, qs;

	// largest magnitude
	always_comb begin
		top01 = (m_q[0] > m_q[1]) ? m_q[0] : m_q[1];
		top23 = (m_q[2] > m_q[3]) ? m_q[2] : m_q[3];
		top = (top01 > top23) ? top01 : top23;
	end

	// root step, numerator setup and one division step
	always_comb begin
		rbit = 51'd1 << {cnt_q, 1'b0};
		rsum = root_q + rbit;
		num = {1'b0, m_q[el_q][23:0], 14'b0} + {14'b0, root_q[25:1]};
		dvs = {1'b0, root_q[25:0]};
		rem_t = {rem_q[25:0], div_lo_q[cnt_q[3:0]]};
		qbit = (rem_t >= dvs);
		qf = {quo_q[14:0], qbit};
		qs = qf[15] ? 16'h7FFF : qf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
			ok_q <= 1'b0;
			cnt_q <= '0;
			el_q <= '0;
			sq_v_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				N_IDLE: begin
					if (start) begin
						for (int i = 0; i < 4; i++) begin
							m_q[i] <= vec[i][63] ? 64'(-vec[i]) : 64'(vec[i]);
							neg_q[i] <= vec[i][63];
						end
						if (!four) begin
							m_q[3] <= '0;
							neg_q[3] <= 1'b0;
						end
						ok_q <= 1'b1;
						state_q <= N_SHIFT;
					end
				end
				// bring the largest magnitude into [2^23, 2^24)
				N_SHIFT: begin
					if (top == 64'd0) begin
						ok_q <= 1'b0;
						state_q <= N_IDLE;
					end else if (top[63:24] != '0) begin
						for (int i = 0; i < 4; i++) m_q[i] <= m_q[i] >> 1;
					end else if (!top[23]) begin
						for (int i = 0; i < 4; i++) m_q[i] <= m_q[i] << 1;
					end else begin
						cnt_q <= '0;
						rn_q <= '0;
						sq_v_s1 <= 1'b0;
						state_q <= N_SQ;
					end
				end
				// sum of squares, multiplier registered
				N_SQ: begin
					sq_s1 <= m_q[cnt_q[1:0]][23:0] * m_q[cnt_q[1:0]][23:0];
					sq_v_s1 <= (cnt_q < 5'd4);
					if (sq_v_s1) rn_q <= rn_q + {2'b0, sq_s1};
					if (cnt_q == 5'd4) begin
						cnt_q <= 5'd24;
						root_q <= '0;
						state_q <= N_ROOT;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				// floor square root, two bits a step
				N_ROOT: begin
					if ({1'b0, rn_q} >= rsum) begin
						rn_q <= rn_q - rsum[49:0];
						root_q <= (root_q >> 1) + rbit;
					end else begin
						root_q <= root_q >> 1;
					end
					if (cnt_q == 5'd0) begin
						el_q <= '0;
						state_q <= N_DLOAD;
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				N_DLOAD: begin
					rem_q <= {4'b0, num[38:16]};
					div_lo_q <= num[15:0];
					quo_q <= '0;
					cnt_q <= 5'd15;
					state_q <= N_DIV;
				end
				// rounded quotient, one bit a step
				N_DIV: begin
					if (qbit) rem_q <= rem_t - dvs;
					else rem_q <= rem_t;
					quo_q <= qf;
					if (cnt_q == 5'd0) begin
						res_q[el_q] <= neg_q[el_q] ? -qs : qs;
						if (el_q == 2'd3) begin
							state_q <= N_IDLE;
						end else begin
							el_q <= el_q + 2'd1;
							state_q <= N_DLOAD;
						end
					end else begin
						cnt_q <= cnt_q - 5'd1;
					end
				end
				default: state_q <= N_IDLE;
			endcase
		end
	end

	assign busy = (state_q != N_IDLE);
	assign ok = ok_q;
	assign res = res_q;
endmodule

// ----- hdl/qoj_cordic.sv -----
// iterative cordic for cosine and sine of the half angle, gain left in
module qoj_cordic (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [15:0] angle,
	output logic busy,
	output logic signed [31:0] cos_out,
	output logic signed [31:0] sin_out
);
	import qoj_pkg::*;

	typedef enum logic {C_IDLE, C_RUN} cstate_t;

	cstate_t state_q;
	logic signed [31:0] x_q, y_q;
	logic signed [34:0] z_q;
	logic [4:0] i_q;
	logic flip_q;

	logic signed [34:0] z0, at;
	logic signed [31:0] xs, ys, nx, ny;

	// half angle in Q30 and one rotation step
	always_comb begin
		z0 = {{2{angle[15]}}, angle, 17'b0};
		at = {3'b0, atan_q30(i_q)};
		xs = x_q >>> i_q;
		ys = y_q >>> i_q;
		if (!z_q[34]) begin
			nx = x_q - ys;
			ny = y_q + xs;
		end else begin
			nx = x_q + ys;
			ny = y_q - xs;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			i_q <= '0;
			flip_q <= 1'b0;
		end else begin
			unique case (state_q)
				C_IDLE: begin
					if (start) begin
						// fold the half angle into [-pi/2, pi/2]
						if (z0 > HalfPiQ30) begin
							z_q <= z0 - PiQ30;
							flip_q <= 1'b1;
						end else if (z0 < -HalfPiQ30) begin
							z_q <= z0 + PiQ30;
							flip_q <= 1'b1;
						end else begin
							z_q <= z0;
							flip_q <= 1'b0;
						end
						x_q <= 32'sd268435456;
						y_q <= '0;
						i_q <= '0;
						state_q <= C_RUN;
					end
				end
				C_RUN: begin
					z_q <= z_q[34] ? z_q + at : z_q - at;
					if (i_q == 5'(CordicIters - 1)) begin
						x_q <= flip_q ? -nx : nx;
						y_q <= flip_q ? -ny : ny;
						state_q <= C_IDLE;
					end else begin
						x_q <= nx;
						y_q <= ny;
						i_q <= i_q + 5'd1;
					end
				end
				default: state_q <= C_IDLE;
			endcase
		end
	end

	assign busy = (state_q != C_IDLE);
	assign cos_out = x_q;
	assign sin_out = y_q;
endmodule

// ----- hdl/qoj_datapath.sv -----
// datapath: orientation registers, multiply-accumulate unit, normalizer and cordic
module qoj_datapath (
	input logic clk,
	input logic arst_n,
	input qoj_pkg::cmd_t cmd,
	output qoj_pkg::status_t status,
	input logic signed [15:0] angle,
	input logic signed [15:0] load_w,
	input logic signed [15:0] load_x,
	input logic signed [15:0] load_y,
	input logic signed [15:0] load_z,
	output logic signed [15:0] quat_w,
	output logic signed [15:0] quat_x,
	output logic signed [15:0] quat_y,
	output logic signed [15:0] quat_z
);
	import qoj_pkg::*;

	typedef struct packed {
		logic en;
		logic neg;
		logic dbl;
		logic clr;
	} mac_ctl_t;

	logic signed [15:0] att_q [4];
	logic signed [15:0] saved_q [4];
	logic signed [15:0] angle_q;
	logic signed [63:0] v_q [4];
	logic signed [15:0] u_q [3];
	logic signed [47:0] r_q [4];
	logic signed [63:0] prod_s1;
	mac_ctl_t mac_s1;
	logic signed [63:0] acc_q;
	logic signed [15:0] out_q [4];

	logic signed [47:0] a_op;
	logic signed [15:0] b_op;
	logic signed [63:0] prod, term;
	logic norm_busy, norm_ok, cordic_busy;
	logic signed [15:0] norm_res [4];
	logic signed [31:0] cx, cy;

	qoj_norm u_norm (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.start_norm),
		.four(cmd.norm_four),
		.vec(v_q),
		.busy(norm_busy),
		.ok(norm_ok),
		.res(norm_res)
	);

	qoj_cordic u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.start_cordic),
		.angle(angle_q),
		.busy(cordic_busy),
		.cos_out(cx),
		.sin_out(cy)
	);

	// operand selection
	always_comb begin
		unique case (cmd.uop.a)
			A_Q0: a_op = {{32{att_q[0][15]}}, att_q[0]};
			A_Q1: a_op = {{32{att_q[1][15]}}, att_q[1]};
			A_Q2: a_op = {{32{att_q[2][15]}}, att_q[2]};
			A_Q3: a_op = {{32{att_q[3][15]}}, att_q[3]};
			A_R0: a_op = r_q[0];
			A_R1: a_op = r_q[1];
			A_R2: a_op = r_q[2];
			A_R3: a_op = r_q[3];
			A_CY: a_op = {{16{cy[31]}}, cy};
			default: a_op = '0;
		endcase
		unique case (cmd.uop.b)
			B_Q0: b_op = att_q[0];
			B_Q1: b_op = att_q[1];
			B_Q2: b_op = att_q[2];
			B_Q3: b_op = att_q[3];
			B_U0: b_op = u_q[0];
			B_U1: b_op = u_q[1];
			B_U2: b_op = u_q[2];
			default: b_op = '0;
		endcase
		prod = a_op * b_op;
		term = mac_s1.dbl ? (prod_s1 <<< 1) : prod_s1;
		if (mac_s1.neg) term = -term;
	end

	// multiply stage and accumulate stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_s1 <= '0;
		end else begin
			mac_s1.en <= (cmd.uop.op == UOP_MAC);
			mac_s1.neg <= cmd.uop.neg;
			mac_s1.dbl <= cmd.uop.dbl;
			mac_s1.clr <= cmd.uop.clr;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		if (mac_s1.en) acc_q <= mac_s1.clr ? term : acc_q + term;
	end

	// accumulator stores, operand captures and result register
	always_ff @(posedge clk) begin
		if (cmd.uop.op == UOP_STORE) begin
			unique case (cmd.uop.dst)
				D_V0: v_q[0] <= acc_q;
				D_V1: v_q[1] <= acc_q;
				D_V2: v_q[2] <= acc_q;
				D_V3: v_q[3] <= acc_q;
				D_R1: r_q[1] <= acc_q[47:0];
				D_R2: r_q[2] <= acc_q[47:0];
				D_R3: r_q[3] <= acc_q[47:0];
				default: ;
			endcase
		end
		if (cmd.capture) angle_q <= angle;
		if (cmd.take_u) begin
			for (int i = 0; i < 3; i++) u_q[i] <= norm_res[i];
			r_q[0] <= {{2{cx[31]}}, cx, 14'b0};
		end
		if (cmd.show) out_q <= att_q;
	end

	// orientation and safe copy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			att_q[0] <= OneQ14;
			saved_q[0] <= OneQ14;
			for (int i = 1; i < 4; i++) begin
				att_q[i] <= '0;
				saved_q[i] <= '0;
			end
		end else begin
			if (cmd.load_att) begin
				att_q[0] <= load_w;
				att_q[1] <= load_x;
				att_q[2] <= load_y;
				att_q[3] <= load_z;
			end else if (cmd.restore) begin
				att_q <= saved_q;
			end else if (cmd.take_att) begin
				att_q <= norm_res;
			end
			if (cmd.save) saved_q <= att_q;
		end
	end

	assign status.norm_busy = norm_busy;
	assign status.norm_ok = norm_ok;
	assign status.cordic_busy = cordic_busy;
	assign quat_w = out_q[0];
	assign quat_x = out_q[1];
	assign quat_y = out_q[2];
	assign quat_z = out_q[3];
endmodule

// ----- hdl/qoj_ctrl.sv -----
// controller: item dispatch, microcode sequencing and output handshake
module qoj_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] kind,
	input logic [1:0] axis,
	output logic out_valid,
	input logic out_ready,
	output qoj_pkg::cmd_t cmd,
	input qoj_pkg::status_t status
);
	import qoj_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_AXIS, S_NSTART1, S_NWAIT1, S_RUN2, S_NSTART2, S_NWAIT2, S_DONE
	} state_t;

	state_t state_q;
	logic [PcW-1:0] pc_q;
	logic out_valid_q;
	logic accept;
	logic units_idle;

	assign in_ready = (state_q == S_IDLE);
	assign accept = in_valid && in_ready;
	assign units_idle = !status.norm_busy && !status.cordic_busy;

	// command decode
	always_comb begin
		cmd = '0;
		cmd.uop = nop();
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.capture = 1'b1;
					cmd.load_att = (kind == KIND_LOAD);
					cmd.save = (kind == KIND_ACCEPT);
					cmd.restore = (kind == KIND_REJECT);
				end
			end
			S_AXIS, S_RUN2: cmd.uop = ucode(pc_q);
			S_NSTART1: begin
				cmd.start_norm = 1'b1;
				cmd.start_cordic = 1'b1;
			end
			S_NWAIT1: cmd.take_u = units_idle && status.norm_ok;
			S_NSTART2: begin
				cmd.start_norm = 1'b1;
				cmd.norm_four = 1'b1;
			end
			S_NWAIT2: cmd.take_att = !status.norm_busy && status.norm_ok;
			S_DONE: cmd.show = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	// sequencer state, program counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.show) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (kind != KIND_ROTATE || axis == AXIS_NONE) begin
							state_q <= S_DONE;
						end else begin
							unique case (axis)
								AXIS_X: pc_q <= PcAxisX;
								AXIS_Y: pc_q <= PcAxisY;
								default: pc_q <= PcAxisZ;
							endcase
							state_q <= S_AXIS;
						end
					end
				end
				S_AXIS: begin
					pc_q <= pc_q + 7'd1;
					if (cmd.uop.last) state_q <= S_NSTART1;
				end
				S_NSTART1: state_q <= S_NWAIT1;
				S_NWAIT1: begin
					if (units_idle) begin
						if (status.norm_ok) begin
							pc_q <= PcRot;
							state_q <= S_RUN2;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_RUN2: begin
					pc_q <= pc_q + 7'd1;
					if (cmd.uop.last) state_q <= S_NSTART2;
				end
				S_NSTART2: state_q <= S_NWAIT2;
				S_NWAIT2: if (!status.norm_busy) state_q <= S_DONE;
				S_DONE: if (cmd.show) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
endmodule

// ----- hdl/quaternion_orientation_jog.sv -----
// top level of the quaternion orientation jog block
//
// Input channel (in_valid/in_ready) takes one transaction per item: kind, axis,
// angle and the load_* orientation. Output channel (out_valid/out_ready) gives
// one transaction per item with the orientation after that item.
// Load, accept and reject items go straight to the done state, which fills the
// output register once it is free; their result can then be taken at the same
// edge at which the next item is taken.
// A rotate item runs the world-axis microcode on the shared multiply-accumulate
// unit, the three-part normalizer alongside the cordic, the rotation and product
// microcode and the four-part normalizer, its run time set mostly by the
// normalizer's bit-serial square root and division and its one-bit-a-cycle
// scaling shifts; an axis of none or a zero world axis ends it early.
// One item is worked on at a time; a finished result sits in the output
// register, so the next item is accepted while it waits. When the receiver
// stalls, the next finished result waits until the output register is free.
// Reset sets the orientation and its safe copy to the identity quaternion
// and empties the output register.
module quaternion_orientation_jog (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [1:0] kind,
	input logic [1:0] axis,
	input logic signed [15:0] angle,
	input logic signed [15:0] load_w,
	input logic signed [15:0] load_x,
	input logic signed [15:0] load_y,
	input logic signed [15:0] load_z,
	output logic out_valid,
	input logic out_ready,
	output logic signed [15:0] quat_w,
	output logic signed [15:0] quat_x,
	output logic signed [15:0] quat_y,
	output logic signed [15:0] quat_z
);
	import qoj_pkg::*;

	cmd_t cmd;
	status_t status;

	qoj_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.axis(axis),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd(cmd),
		.status(status)
	);

	qoj_datapath u_datapath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.status(status),
		.angle(angle),
		.load_w(load_w),
		.load_x(load_x),
		.load_y(load_y),
		.load_z(load_z),
		.quat_w(quat_w),
		.quat_x(quat_x),
		.quat_y(quat_y),
		.quat_z(quat_z)
	);
endmodule

// ----- hdl/qoj_checker.sv -----
// port-level checker for the quaternion orientation jog block, with its bind
module qoj_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic [1:0] kind,
	input logic signed [15:0] load_w,
	input logic signed [15:0] load_z,
	input logic out_valid,
	input logic out_ready,
	input logic signed [15:0] quat_w,
	input logic signed [15:0] quat_x,
	input logic signed [15:0] quat_y,
	input logic signed [15:0] quat_z
);
	import qoj_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(quat_w) && $stable(quat_x)
			&& $stable(quat_y) && $stable(quat_z))
		else $error("stalled result changed");

	// one item at a time: busy right after a transaction
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

	// a load with a free output shows the loaded orientation, via the done state and the output register
	a_load_shown: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && kind == KIND_LOAD && !out_valid |-> ##2
			(out_valid && quat_w == $past(load_w, 2) && quat_z == $past(load_z, 2)))
		else $error("loaded orientation not shown");
endmodule

bind quaternion_orientation_jog qoj_checker u_qoj_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.kind(kind),
	.load_w(load_w),
	.load_z(load_z),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.quat_w(quat_w),
	.quat_x(quat_x),
	.quat_y(quat_y),
	.quat_z(quat_z)
);

// ----- tb/quaternion_orientation_jog_tb.sv -----
// self-checking testbench for the quaternion orientation jog block
module quaternion_orientation_jog_tb;
	import qoj_pkg::*;

	typedef longint quad_t [4];
	typedef logic signed [15:0] att_t [4];

	typedef struct {
		logic [1:0] kind;
		logic [1:0] axis;
		logic signed [15:0] angle;
		logic signed [15:0] lw, lx, ly, lz;
		bit typed;
		logic signed [15:0] ew, ex, ey, ez;
	} stim_row_t;

	typedef struct {
		logic signed [15:0] w, x, y, z;
	} attitude_t;

	localparam int RandomItems = 1900;
	localparam int WatchdogLimit = 5000;
	localparam int LongHold = 400;
	localparam int DrainCycles = 400;

	// arctangent of 2^-i in Q30, truncated
	localparam longint AtanQ30 [24] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76, 64'h01FFD55B,
		64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
		64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF, 64'h00003FFF, 64'h00001FFF,
		64'h00000FFF, 64'h000007FF, 64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] kind = KIND_ACCEPT;
	logic [1:0] axis = AXIS_X;
	logic signed [15:0] angle = '0;
	logic signed [15:0] load_w = '0;
	logic signed [15:0] load_x = '0;
	logic signed [15:0] load_y = '0;
	logic signed [15:0] load_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [15:0] quat_w, quat_x, quat_y, quat_z;

	// values seen at the falling edge, stable through the next rising edge
	logic in_ready_s = 1'b0;
	logic out_valid_s = 1'b0;
	logic signed [15:0] qw_s, qx_s, qy_s, qz_s;

	att_t cur_att;
	att_t safe_att;
	attitude_t expected_attitudes [$];
	stim_row_t directed_rows [$];

	int errors = 0;
	int n_rotate = 0, n_load = 0, n_accept = 0, n_reject = 0, n_checked = 0;
	int idle_cycles = 0;
	bit no_idle = 1'b0;
	bit hold_req = 1'b0;

	quaternion_orientation_jog i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.axis(axis),
		.angle(angle),
		.load_w(load_w),
		.load_x(load_x),
		.load_y(load_y),
		.load_z(load_z),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.quat_w(quat_w),
		.quat_x(quat_x),
		.quat_y(quat_y),
		.quat_z(quat_z)
	);

	// clock and reset
	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(negedge clk) begin
		in_ready_s <= in_ready;
		out_valid_s <= out_valid;
		qw_s <= quat_w;
		qx_s <= quat_x;
		qy_s <= quat_y;
		qz_s <= quat_z;
	end

	// hamilton product
	function automatic quad_t hamilton(quad_t a, quad_t b);
		quad_t r;
		r[0] = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
		r[1] = a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2];
		r[2] = a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1];
		r[3] = a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0];
		return r;
	endfunction

	// floor integer square root, digit by digit
	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n)
			bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// scale n parts to a Q2.14 unit; zero when every part is zero
	function automatic bit unit_scale(quad_t v, int n, output att_t o);
		longint unsigned m [4];
		longint unsigned top, sum, nrm, q;
		top = 0;
		sum = 0;
		o = '{default: '0};
		for (int i = 0; i < n; i++) begin
			m[i] = v[i] < 0 ? 64'd0 - longint'(v[i]) : v[i];
			if (m[i] > top)
				top = m[i];
		end
		if (top == 0)
			return 1'b0;
		while (top >= (64'd1 << 24)) begin
			for (int i = 0; i < n; i++)
				m[i] >>= 1;
			top >>= 1;
		end
		while (top < (64'd1 << 23)) begin
			for (int i = 0; i < n; i++)
				m[i] <<= 1;
			top <<= 1;
		end
		for (int i = 0; i < n; i++)
			sum += m[i] * m[i];
		nrm = root_floor(sum);
		for (int i = 0; i < n; i++) begin
			q = (m[i] * 16384 + nrm / 2) / nrm;
			if (q > 32767)
				q = 32767;
			o[i] = v[i] < 0 ? -16'(q) : 16'(q);
		end
		return 1'b1;
	endfunction

	// jog the current attitude about a body axis
	task automatic jog_attitude(logic [1:0] ax, logic signed [15:0] ang);
		quad_t q, qc, e, g, vec, r, p;
		att_t u, np;
		longint x, y, z, nx;
		bit flip;
		if (ax == AXIS_NONE)
			return;
		for (int i = 0; i < 4; i++) begin
			q[i] = cur_att[i];
			qc[i] = i == 0 ? q[i] : -q[i];
			e[i] = (i == int'(ax) + 1) ? 1 : 0;
		end
		g = hamilton(hamilton(q, e), qc);
		vec = '{g[1], g[2], g[3], 0};
		if (!unit_scale(vec, 3, u))
			return;
		z = longint'(ang) * (64'sd1 <<< 17);
		flip = 1'b0;
		if (z > longint'(HalfPiQ30)) begin
			z -= longint'(PiQ30);
			flip = 1'b1;
		end else if (z < -longint'(HalfPiQ30)) begin
			z += longint'(PiQ30);
			flip = 1'b1;
		end
		x = 64'sd1 <<< 28;
		y = 0;
		for (int i = 0; i < CordicIters; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= AtanQ30[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += AtanQ30[i];
			end
			x = nx;
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		r = '{x * 16384, y * u[0], y * u[1], y * u[2]};
		p = hamilton(r, q);
		if (unit_scale(p, 4, np))
			cur_att = np;
	endtask

	// apply one accepted transaction to the predicted state
	task automatic apply_item(stim_row_t s);
		case (s.kind)
			KIND_ROTATE: begin
				jog_attitude(s.axis, s.angle);
				n_rotate++;
			end
			KIND_LOAD: begin
				cur_att = '{s.lw, s.lx, s.ly, s.lz};
				n_load++;
			end
			KIND_ACCEPT: begin
				safe_att = cur_att;
				n_accept++;
			end
			default: begin
				cur_att = safe_att;
				n_reject++;
			end
		endcase
	endtask

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
		errors++;
	endtask

	task automatic add_row(logic [1:0] k, logic [1:0] a, int ang, int w, int x, int y, int z,
			bit typed, int ew = 0, int ex = 0, int ey = 0, int ez = 0);
		stim_row_t s;
		s = '{k, a, 16'(ang), 16'(w), 16'(x), 16'(y), 16'(z), typed,
			16'(ew), 16'(ex), 16'(ey), 16'(ez)};
		directed_rows = {directed_rows, s};
	endtask

	// drive one transaction and record its expected attitude on acceptance
	task automatic send_item(stim_row_t s);
		int unsigned gap;
		attitude_t e;
		gap = no_idle ? 0 : $urandom_range(0, 11);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= s.kind;
		axis <= s.axis;
		angle <= s.angle;
		load_w <= s.lw;
		load_x <= s.lx;
		load_y <= s.ly;
		load_z <= s.lz;
		@(posedge clk);
		while (!in_ready_s)
			@(posedge clk);
		apply_item(s);
		if (s.typed)
			e = '{s.ew, s.ex, s.ey, s.ez};
		else
			e = '{cur_att[0], cur_att[1], cur_att[2], cur_att[3]};
		expected_attitudes = {expected_attitudes, e};
	endtask

	function automatic stim_row_t random_item();
		stim_row_t s;
		int unsigned pick;
		s = '{default: '0};
		pick = $urandom_range(0, 99);
		if (pick < 60)
			s.kind = KIND_ROTATE;
		else if (pick < 74)
			s.kind = KIND_LOAD;
		else if (pick < 87)
			s.kind = KIND_ACCEPT;
		else
			s.kind = KIND_REJECT;
		s.axis = ($urandom_range(0, 19) == 0) ? AXIS_NONE : 2'($urandom_range(0, 2));
		s.angle = ($urandom_range(0, 2) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8192) - 4096);
		if ($urandom_range(0, 3) == 0) begin
			s.lw = 16'($urandom);
			s.lx = 16'($urandom);
			s.ly = 16'($urandom);
			s.lz = 16'($urandom);
		end else begin
			// mostly near-unit orientations
			s.lw = 16'($urandom_range(0, 32768) - 16384);
			s.lx = 16'($urandom_range(0, 32768) - 16384);
			s.ly = 16'($urandom_range(0, 32768) - 16384);
			s.lz = 16'($urandom_range(0, 32768) - 16384);
		end
		return s;
	endfunction

	// result side: random stalls, one long hold on request
	initial begin
		int unsigned stall;
		attitude_t e;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_ready <= 1'b0;
				repeat (LongHold) @(posedge clk);
			end else begin
				stall = no_idle ? 0 : $urandom_range(0, 11);
				if (stall != 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid_s)
				@(posedge clk);
			if (expected_attitudes.size() == 0) begin
				report("unexpected transaction", qw_s, 0);
			end else begin
				e = expected_attitudes.pop_front();
				n_checked++;
				if (qw_s !== e.w) report("quat_w", qw_s, e.w);
				if (qx_s !== e.x) report("quat_x", qx_s, e.x);
				if (qy_s !== e.y) report("quat_y", qy_s, e.y);
				if (qz_s !== e.z) report("quat_z", qz_s, e.z);
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready_s) || (out_ready && out_valid_s))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("watchdog expired with %0d results pending", expected_attitudes.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// stimulus
	initial begin
		cur_att = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
		safe_att = cur_att;

		// directed: reset state, extremes, axis none, zero attitude, range reduction
		add_row(KIND_ACCEPT, AXIS_X, 0, 0, 0, 0, 0, 1, 16384, 0, 0, 0);
		add_row(KIND_ROTATE, AXIS_NONE, 1234, 0, 0, 0, 0, 1, 16384, 0, 0, 0);
		add_row(KIND_ROTATE, AXIS_X, 0, 0, 0, 0, 0, 0);
		add_row(KIND_ROTATE, AXIS_X, 32767, 0, 0, 0, 0, 0);
		add_row(KIND_ROTATE, AXIS_Y, -32768, 0, 0, 0, 0, 0);
		add_row(KIND_ROTATE, AXIS_Z, 6434, 0, 0, 0, 0, 0);
		add_row(KIND_ROTATE, AXIS_Z, -6434, 0, 0, 0, 0, 0);
		add_row(KIND_ROTATE, AXIS_X, 12868, 0, 0, 0, 0, 0);
		add_row(KIND_LOAD, AXIS_X, 0, 32767, -32768, 32767, -32768, 1,
			32767, -32768, 32767, -32768);
		add_row(KIND_ROTATE, AXIS_Y, 1000, 0, 0, 0, 0, 0);
		add_row(KIND_REJECT, AXIS_X, 0, 0, 0, 0, 0, 1, 16384, 0, 0, 0);
		add_row(KIND_LOAD, AXIS_X, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
		add_row(KIND_ROTATE, AXIS_Z, 5000, 0, 0, 0, 0, 1, 0, 0, 0, 0);
		add_row(KIND_ACCEPT, AXIS_X, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
		add_row(KIND_LOAD, AXIS_X, 0, 16384, 0, 0, 0, 1, 16384, 0, 0, 0);
		add_row(KIND_ROTATE, AXIS_X, 1, 0, 0, 0, 0, 0);
		add_row(KIND_ROTATE, AXIS_Y, -1, 0, 0, 0, 0, 0);
		add_row(KIND_REJECT, AXIS_X, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0);
		add_row(KIND_LOAD, AXIS_Z, 0, -32768, 32767, -1, 1, 1, -32768, 32767, -1, 1);
		add_row(KIND_ROTATE, AXIS_Z, -20000, 0, 0, 0, 0, 0);
		add_row(KIND_ACCEPT, AXIS_Y, 0, 0, 0, 0, 0, 0);

		@(posedge arst_n);
		@(posedge clk);
		foreach (directed_rows[i])
			send_item(directed_rows[i]);

		// random part with one long receiver hold, one full drain and a burst stretch
		for (int i = 0; i < RandomItems; i++) begin
			if (i == 600)
				hold_req = 1'b1;
			if (i == 1200) begin
				// stop offering while the block drains
				in_valid <= 1'b0;
				@(posedge clk);
				wait (expected_attitudes.size() == 0);
			end
			no_idle = (i >= 800 && i < 1000);
			send_item(random_item());
		end
		in_valid <= 1'b0;

		wait (expected_attitudes.size() == 0);
		repeat (DrainCycles) @(posedge clk);
		$display("covered %0d rotate, %0d load, %0d accept, %0d reject transactions",
			n_rotate, n_load, n_accept, n_reject);
		$display("%0d results compared, %0d mismatches", n_checked, errors);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- quaternion_orientation_jog.f -----
hdl/qoj_pkg.sv
hdl/qoj_norm.sv
hdl/qoj_cordic.sv
hdl/qoj_datapath.sv
hdl/qoj_ctrl.sv
hdl/quaternion_orientation_jog.sv
hdl/qoj_checker.sv
tb/quaternion_orientation_jog_tb.sv
